FILE: hdl/fault_record_table_unit_macros.svh
`ifndef FAULT_RECORD_TABLE_UNIT_MACROS_SVH
`define FAULT_RECORD_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define FRT_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("fault record table check failed");
// next-cycle implication, sampled on clk, off during reset
`define FRT_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("fault record table check failed");
`else
`define FRT_ASSERT_IMP(lbl, ant, cons)
`define FRT_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

FILE: hdl/frt_pkg.sv
package frt_pkg;

  localparam int FAULT_SLOTS = 32;
  localparam int IDX_W       = (FAULT_SLOTS > 1) ? $clog2(FAULT_SLOTS) : 1;
  localparam int CNT_W       = $clog2(FAULT_SLOTS + 1);
  localparam int SEV_LEVELS  = 4;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [1:0]  CRIT_LEVEL_RST = 2'd3;

  localparam logic [1:0] OP_REPORT = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  fault_code;
    logic [1:0]  severity;
    logic [63:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        code_valid;
    logic        rec_active;
    logic [1:0]  rec_severity;
    logic [31:0] rec_occurrences;
    logic [63:0] rec_first_time;
    logic [63:0] rec_last_time;
    logic        any_active_critical;
    logic        ever_critical_seen;
    logic [31:0] total_count;
    logic [5:0]  active_total;
  } out_item_t;

  typedef struct packed {
    logic        active;
    logic [1:0]  severity;
    logic [31:0] occurrences;
    logic [63:0] first_time;
    logic [63:0] last_time;
  } rec_t;

endpackage

FILE: hdl/fault_record_table_unit.sv
// Fault record table: one record per fault code (active flag, severity,
// saturating occurrence count, first and last report time) held in a
// single-port synchronous memory, plus running totals in registers. The record
// is read from memory at the accept edge; in the update state that follows, the
// updated record is written back and the result is loaded into the output
// register, and no new item is taken until the last one has left the update
// state. A finished result waits in the output register; the
// next item is still accepted and stalls only in its update cycle until that
// register frees up. Entries read as zero until first written (one valid flop
// per entry, cleared by reset, no clearing pass). Active records are counted
// per severity, so a write of critical_level takes effect at once; write it
// only while no item is in flight.
`include "fault_record_table_unit_macros.svh"

module fault_record_table_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  frt_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output frt_pkg::out_item_t out_item,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data
);

  frt_pkg::rec_t mem [frt_pkg::FAULT_SLOTS];
  logic [frt_pkg::FAULT_SLOTS-1:0] vld_r;

  frt_pkg::state_t state_r, state_nxt;
  frt_pkg::in_item_t item_r;
  logic              code_ok_r;
  logic [frt_pkg::IDX_W-1:0] idx_r;
  frt_pkg::rec_t     rd_rec_r;
  logic              rd_vld_r;

  logic [1:0]  crit_level_r;
  logic        sticky_r, sticky_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [5:0]  act_cnt_r, act_cnt_nxt;
  logic [frt_pkg::CNT_W-1:0] sev_cnt_r   [frt_pkg::SEV_LEVELS];
  logic [frt_pkg::CNT_W-1:0] sev_cnt_nxt [frt_pkg::SEV_LEVELS];

  frt_pkg::out_item_t out_item_r, out_item_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic                      in_fire, fire, wr_en;
  logic                      in_code_ok;
  logic [frt_pkg::IDX_W-1:0] in_idx;
  frt_pkg::rec_t             old_rec, new_rec;

  assign in_code_ok = {1'b0, in_item.fault_code} < 9'(frt_pkg::FAULT_SLOTS);
  assign in_idx     = in_code_ok ? in_item.fault_code[frt_pkg::IDX_W-1:0] : '0;
  assign in_fire    = in_valid && in_ready;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    fire      = 1'b0;
    case (state_r)
      frt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = frt_pkg::ST_CALC;
        end
      end
      frt_pkg::ST_CALC: begin
        if (!out_valid_r || out_ready) begin
          fire      = 1'b1;
          state_nxt = frt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = frt_pkg::ST_IDLE;
      end
    endcase
  end

  // record read at accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r    <= in_item;
      code_ok_r <= in_code_ok;
      idx_r     <= in_idx;
      rd_rec_r  <= mem[in_idx];
      rd_vld_r  <= vld_r[in_idx];
    end
  end

  // record update
  always_comb begin
    logic report, clear, occ_ok, inc, dec;
    report = code_ok_r && (item_r.operation == frt_pkg::OP_REPORT);
    clear  = code_ok_r && (item_r.operation == frt_pkg::OP_CLEAR);
    old_rec = rd_vld_r ? rd_rec_r : '0;
    new_rec = old_rec;
    occ_ok  = old_rec.occurrences != frt_pkg::COUNT_MAX;
    sum_nxt     = sum_r;
    sticky_nxt  = sticky_r;
    act_cnt_nxt = act_cnt_r;
    if (report) begin
      new_rec.active    = 1'b1;
      new_rec.severity  = item_r.severity;
      new_rec.last_time = item_r.now_ms;
      if (old_rec.occurrences == '0) begin
        new_rec.first_time = item_r.now_ms;
      end
      if (occ_ok) begin
        new_rec.occurrences = old_rec.occurrences + 32'd1;
        sum_nxt             = sum_r + 32'd1;
      end
      if (item_r.severity == crit_level_r) begin
        sticky_nxt = 1'b1;
      end
      if (!old_rec.active) begin
        act_cnt_nxt = act_cnt_r + 6'd1;
      end
    end else if (clear && old_rec.active) begin
      new_rec.active = 1'b0;
      act_cnt_nxt    = act_cnt_r - 6'd1;
    end
    for (int s = 0; s < frt_pkg::SEV_LEVELS; s++) begin
      inc = report && (item_r.severity == 2'(s));
      dec = (report || clear) && old_rec.active && (old_rec.severity == 2'(s));
      sev_cnt_nxt[s] = sev_cnt_r[s] + frt_pkg::CNT_W'(inc) - frt_pkg::CNT_W'(dec);
    end
    wr_en = fire && (report || clear);

    out_item_nxt.code_valid          = code_ok_r;
    out_item_nxt.rec_active          = code_ok_r && new_rec.active;
    out_item_nxt.rec_severity        = new_rec.severity;
    out_item_nxt.rec_occurrences     = new_rec.occurrences;
    out_item_nxt.rec_first_time      = new_rec.first_time;
    out_item_nxt.rec_last_time       = new_rec.last_time;
    out_item_nxt.any_active_critical = sev_cnt_nxt[crit_level_r] != '0;
    out_item_nxt.ever_critical_seen  = sticky_nxt;
    out_item_nxt.total_count         = sum_nxt;
    out_item_nxt.active_total        = act_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= new_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // running totals and level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_level_r <= frt_pkg::CRIT_LEVEL_RST;
      sticky_r     <= 1'b0;
      sum_r        <= '0;
      act_cnt_r    <= '0;
      for (int s = 0; s < frt_pkg::SEV_LEVELS; s++) begin
        sev_cnt_r[s] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        crit_level_r <= cfg_wr_data;
      end
      if (fire) begin
        sticky_r  <= sticky_nxt;
        sum_r     <= sum_nxt;
        act_cnt_r <= act_cnt_nxt;
        for (int s = 0; s < frt_pkg::SEV_LEVELS; s++) begin
          sev_cnt_r[s] <= sev_cnt_nxt[s];
        end
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `FRT_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `FRT_ASSERT_NXT(a_fire_loads_out, fire, out_valid)
  `FRT_ASSERT_NXT(a_stall_holds, (state_r == frt_pkg::ST_CALC) && out_valid_r && !out_ready,
    (state_r == frt_pkg::ST_CALC) && out_valid_r)
  `FRT_ASSERT_IMP(a_sev_cnt_bound, 1'b1,
    ((frt_pkg::CNT_W+2)'(sev_cnt_r[0]) + (frt_pkg::CNT_W+2)'(sev_cnt_r[1]) +
     (frt_pkg::CNT_W+2)'(sev_cnt_r[2]) + (frt_pkg::CNT_W+2)'(sev_cnt_r[3]))
    <= (frt_pkg::CNT_W+2)'(frt_pkg::FAULT_SLOTS))

endmodule

FILE: sim/fault_table_checker.sv
`timescale 1ns / 1ps

module fault_table_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  frt_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  frt_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  output int                 pending,
  output int                 errors
);

  frt_pkg::rec_t      records [frt_pkg::FAULT_SLOTS];
  logic               sticky_crit;
  logic [31:0]        occ_sum;
  int                 active_num;
  int                 crit_active_num;
  logic [1:0]         crit_level;
  frt_pkg::out_item_t expected_results [$];
  frt_pkg::out_item_t predicted;
  frt_pkg::out_item_t oldest;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic counts_as_critical(input int i);
    return records[i].active && records[i].severity == crit_level;
  endfunction

  task automatic clear_table();
    for (int i = 0; i < frt_pkg::FAULT_SLOTS; i++) records[i] = '0;
    sticky_crit = 1'b0;
    occ_sum = '0;
    active_num = 0;
    crit_active_num = 0;
    crit_level = frt_pkg::CRIT_LEVEL_RST;
  endtask

  task automatic recount_critical();
    crit_active_num = 0;
    for (int i = 0; i < frt_pkg::FAULT_SLOTS; i++)
      if (counts_as_critical(i)) crit_active_num++;
  endtask

  task automatic apply_fault_item(input frt_pkg::in_item_t it,
                                  output frt_pkg::out_item_t res);
    logic code_ok;
    int   idx;
    code_ok = it.fault_code < frt_pkg::FAULT_SLOTS;
    idx = code_ok ? int'(it.fault_code) : 0;
    if (code_ok && it.operation == frt_pkg::OP_REPORT) begin
      if (counts_as_critical(idx)) crit_active_num--;
      if (!records[idx].active) active_num++;
      if (records[idx].occurrences == '0) records[idx].first_time = it.now_ms;
      records[idx].severity = it.severity;
      records[idx].active = 1'b1;
      records[idx].last_time = it.now_ms;
      if (records[idx].occurrences != frt_pkg::COUNT_MAX) begin
        records[idx].occurrences++;
        occ_sum++;
      end
      if (it.severity == crit_level) begin
        sticky_crit = 1'b1;
        crit_active_num++;
      end
    end else if (code_ok && it.operation == frt_pkg::OP_CLEAR && records[idx].active) begin
      if (counts_as_critical(idx)) crit_active_num--;
      records[idx].active = 1'b0;
      active_num--;
    end
    res.code_valid          = code_ok;
    res.rec_active          = code_ok && records[idx].active;
    res.rec_severity        = records[idx].severity;
    res.rec_occurrences     = records[idx].occurrences;
    res.rec_first_time      = records[idx].first_time;
    res.rec_last_time       = records[idx].last_time;
    res.any_active_critical = crit_active_num != 0;
    res.ever_critical_seen  = sticky_crit;
    res.total_count         = occ_sum;
    res.active_total        = active_num[5:0];
  endtask

  task automatic compare_result(input frt_pkg::out_item_t got,
                                input frt_pkg::out_item_t want);
    if (got.code_valid !== want.code_valid)
      report_mismatch("code_valid", got.code_valid, want.code_valid);
    if (got.rec_active !== want.rec_active)
      report_mismatch("rec_active", got.rec_active, want.rec_active);
    if (got.rec_severity !== want.rec_severity)
      report_mismatch("rec_severity", got.rec_severity, want.rec_severity);
    if (got.rec_occurrences !== want.rec_occurrences)
      report_mismatch("rec_occurrences", got.rec_occurrences, want.rec_occurrences);
    if (got.rec_first_time !== want.rec_first_time)
      report_mismatch("rec_first_time", got.rec_first_time, want.rec_first_time);
    if (got.rec_last_time !== want.rec_last_time)
      report_mismatch("rec_last_time", got.rec_last_time, want.rec_last_time);
    if (got.any_active_critical !== want.any_active_critical)
      report_mismatch("any_active_critical", got.any_active_critical,
                      want.any_active_critical);
    if (got.ever_critical_seen !== want.ever_critical_seen)
      report_mismatch("ever_critical_seen", got.ever_critical_seen,
                      want.ever_critical_seen);
    if (got.total_count !== want.total_count)
      report_mismatch("total_count", got.total_count, want.total_count);
    if (got.active_total !== want.active_total)
      report_mismatch("active_total", got.active_total, want.active_total);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
      expected_results.delete();
      pending = 0;
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, total_count",
                          out_item.total_count, '0);
        end else begin
          oldest = expected_results.pop_front();
          compare_result(out_item, oldest);
        end
      end
      if (in_valid && in_ready) begin
        apply_fault_item(in_item, predicted);
        expected_results.push_back(predicted);
      end
      if (cfg_wr_en) begin
        crit_level = cfg_wr_data;
        recount_critical();
      end
      pending = expected_results.size();
    end
  end

endmodule

FILE: sim/tb_fault_record_table_unit.sv
`timescale 1ns / 1ps

module tb_fault_record_table_unit;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         IDLE_LIMIT = 2000;
  localparam int         PHASE_ITEMS = 133;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  frt_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  frt_pkg::out_item_t out_item;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_wr_data = '0;

  int pending;
  int errors;
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int item_count = 0;
  int op_count [4] = '{0, 0, 0, 0};
  logic [1:0] level_plan [4] = '{2'd0, 2'd2, 2'd1, 2'd3};

  fault_record_table_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  fault_table_checker table_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pending     (pending),
    .errors      (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL fault_record_table_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic frt_pkg::in_item_t fault_item(input logic [1:0] op,
                                                   input logic [7:0] code,
                                                   input logic [1:0] sev,
                                                   input logic [63:0] now);
    frt_pkg::in_item_t it;
    it.operation  = op;
    it.fault_code = code;
    it.severity   = sev;
    it.now_ms     = now;
    return it;
  endfunction

  function automatic frt_pkg::in_item_t random_fault_item();
    frt_pkg::in_item_t it;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) it.operation = frt_pkg::OP_REPORT;
    else if (pick < 65) it.operation = frt_pkg::OP_CLEAR;
    else if (pick < 92) it.operation = frt_pkg::OP_QUERY;
    else it.operation = OP_UNUSED;
    pick = $urandom_range(0, 99);
    // most traffic on a few codes so records get reported, cleared and re-reported
    if (pick < 50) it.fault_code = 8'($urandom_range(0, 7));
    else if (pick < 85) it.fault_code = 8'($urandom_range(0, frt_pkg::FAULT_SLOTS - 1));
    else it.fault_code = 8'($urandom_range(frt_pkg::FAULT_SLOTS, 255));
    it.severity = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 8) it.now_ms = '0;
    else if (pick < 16) it.now_ms = '1;
    else it.now_ms = {$urandom, $urandom};
    return it;
  endfunction

  task automatic send_item(input frt_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    item_count++;
    op_count[it.operation]++;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_critical_level(input logic [1:0] lvl);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lvl;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct   = 18;
    stall_pct = 85;

    // directed: extremes, every operation, invalid codes, repeat reports, clears
    send_item(fault_item(frt_pkg::OP_QUERY,  8'd0,   2'd0, '0));
    send_item(fault_item(frt_pkg::OP_REPORT, 8'd0,   2'd3, '1));
    send_item(fault_item(frt_pkg::OP_REPORT, 8'd0,   2'd1, '0));
    send_item(fault_item(frt_pkg::OP_REPORT, 8'd31,  2'd3, 64'h8000_0000_0000_0000));
    send_item(fault_item(frt_pkg::OP_REPORT, 8'd31,  2'd2, 64'd1));
    send_item(fault_item(frt_pkg::OP_REPORT, 8'd5,   2'd3, 64'h5555_5555_5555_5555));
    send_item(fault_item(frt_pkg::OP_CLEAR,  8'd5,   2'd0, '0));
    send_item(fault_item(frt_pkg::OP_CLEAR,  8'd5,   2'd3, '1));
    send_item(fault_item(frt_pkg::OP_CLEAR,  8'd7,   2'd1, '0));
    send_item(fault_item(frt_pkg::OP_QUERY,  8'd32,  2'd0, '0));
    send_item(fault_item(frt_pkg::OP_REPORT, 8'd32,  2'd3, '1));
    send_item(fault_item(frt_pkg::OP_CLEAR,  8'd255, 2'd0, '0));
    send_item(fault_item(frt_pkg::OP_REPORT, 8'd255, 2'd3, 64'h0123_4567_89AB_CDEF));
    send_item(fault_item(frt_pkg::OP_QUERY,  8'd255, 2'd3, '1));
    send_item(fault_item(OP_UNUSED,          8'd0,   2'd3, '1));
    send_item(fault_item(OP_UNUSED,          8'd40,  2'd0, '0));
    send_item(fault_item(frt_pkg::OP_QUERY,  8'd31,  2'd0, '0));
    send_item(fault_item(frt_pkg::OP_REPORT, 8'd10,  2'd0, 64'hAAAA_AAAA_AAAA_AAAA));
    send_item(fault_item(frt_pkg::OP_REPORT, 8'd10,  2'd3, 64'hFEDC_BA98_7654_3210));
    send_item(fault_item(frt_pkg::OP_CLEAR,  8'd0,   2'd0, '0));
    send_item(fault_item(frt_pkg::OP_CLEAR,  8'd31,  2'd0, '0));
    send_item(fault_item(frt_pkg::OP_QUERY,  8'd10,  2'd0, '0));

    for (int phase = 0; phase < 4; phase++) begin
      set_critical_level(level_plan[phase]);
      gap_pct   = (phase == 0) ? 18 : (phase == 1) ? 85 : 0;
      stall_pct = (phase == 0) ? 85 : (phase == 1) ? 18 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 60) wait_drained();
        send_item(random_fault_item());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    $display("run covered %0d items: %0d report, %0d clear, %0d query, %0d unused op",
             item_count, op_count[frt_pkg::OP_REPORT], op_count[frt_pkg::OP_CLEAR],
             op_count[frt_pkg::OP_QUERY], op_count[OP_UNUSED]);
    $display("critical level stepped through all four values; %0d mismatches", errors);
    if (errors == 0) begin
      $display("PASS fault_record_table_unit");
    end else begin
      $display("FAIL fault_record_table_unit");
    end
    $finish;
  end

endmodule
